// ----- rtl/core/rrc4_pkg.sv -----
// Shared types and constants for the reduced RC4 stream cipher.
// No dependencies; rrc4_table, rrc4_seq and the top level import this package.
package rrc4_pkg;

    // Permutation size; kept a power of two so index arithmetic wraps naturally
    localparam int STATE_SIZE = 8;
    localparam int IDX_W      = $clog2(STATE_SIZE);

    localparam int KEY_W      = 64;
    localparam int KLEN_W     = 4;
    localparam int KEY_MAX    = 8;
    localparam int KCNT_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;

    typedef logic [IDX_W-1:0] idx_t;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = CFG_IDX_W'(1);

    // Command codes
    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_RDJ,    // S[i] back, form j, read S[j]
        ST_D_WRI,    // S[i] <= S[j], form keystream index
        ST_D_WRJ,    // S[j] <= S[i], emit result
        ST_K_RDP,    // read S[p]
        ST_K_ADDP,   // j += S[p]
        ST_K_ADDK,   // j += key byte, read S[j]
        ST_K_WRP,    // S[p] <= S[j]
        ST_K_WRJ     // S[j] <= S[p], advance p
    } state_t;

    // Operand pairs of the shared adder
    typedef enum logic [1:0] {
        ADD_I_ONE,
        ADD_J_RDA,
        ADD_J_KEY,
        ADD_SA_RDB
    } add_op_t;

    typedef enum logic [1:0] {
        WR_I,
        WR_J,
        WR_POS
    } wr_sel_t;

    typedef enum logic [1:0] {
        RA_SUM,
        RA_T,
        RA_POS
    } ra_sel_t;

    // Control bundle from the sequencer to the datapath
    typedef struct packed {
        logic    in_ready;
        logic    item_data;
        logic    item_key;
        add_op_t add_op;
        logic    ld_j;
        logic    ld_sa;
        logic    ld_sb;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    wr_from_sa;
        ra_sel_t ra_sel;
        logic    out_ld;
        logic    pos_step;
        logic    key_done;
    } ctrl_t;

endpackage

// ----- rtl/core/rrc4_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module rrc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the contents before a same-cycle write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/core/rrc4_table.sv -----
// Permutation table: RAM plus per-entry valid bits; an unwritten entry reads as its index.
// Depends on rrc4_pkg and rrc4_ram.
module rrc4_table import rrc4_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic clear,
    input  logic we,
    input  idx_t waddr,
    input  idx_t wdata,
    input  idx_t raddr_a,
    input  idx_t raddr_b,
    output idx_t rdata_a,
    output idx_t rdata_b
);

    logic [STATE_SIZE-1:0] valid_reg, valid_next;
    logic                  vld_a_reg, vld_b_reg;
    idx_t                  addr_a_reg, addr_b_reg;
    idx_t                  ram_a, ram_b;

    rrc4_ram #(
        .WIDTH (IDX_W),
        .DEPTH (STATE_SIZE)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // Valid bits: clear restores the identity at once
    always_comb begin
        valid_next = valid_reg;
        if (clear) begin
            valid_next = '0;
        end else if (we) begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Track address and valid bit alongside the registered read
    always_ff @(posedge aclk) begin
        addr_a_reg <= raddr_a;
        addr_b_reg <= raddr_b;
        vld_a_reg  <= valid_reg[raddr_a];
        vld_b_reg  <= valid_reg[raddr_b];
    end

    assign rdata_a = vld_a_reg ? ram_a : addr_a_reg;
    assign rdata_b = vld_b_reg ? ram_b : addr_b_reg;

endmodule

// ----- rtl/core/rrc4_seq.sv -----
// Sequencer for data steps and the key schedule; drives the shared adder and table.
// Depends on rrc4_pkg.
module rrc4_seq import rrc4_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  cmd,
    input  logic  out_free,
    input  logic  last_pos,
    output ctrl_t ctrl
);

    state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (cmd == CMD_RESTART) ? ST_K_RDP : ST_D_RDJ;
                end
            end
            ST_D_RDJ:  state_next = ST_D_WRI;
            ST_D_WRI:  state_next = ST_D_WRJ;
            ST_D_WRJ: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_K_RDP:  state_next = ST_K_ADDP;
            ST_K_ADDP: state_next = ST_K_ADDK;
            ST_K_ADDK: state_next = ST_K_WRP;
            ST_K_WRP:  state_next = ST_K_WRJ;
            ST_K_WRJ:  state_next = last_pos ? ST_IDLE : ST_K_RDP;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control outputs
    always_comb begin
        ctrl            = '0;
        ctrl.add_op     = ADD_I_ONE;
        ctrl.wr_sel     = WR_I;
        ctrl.ra_sel     = RA_SUM;
        case (state_reg)
            ST_IDLE: begin
                ctrl.in_ready  = 1'b1;
                ctrl.item_data = s_valid && (cmd == CMD_DATA);
                ctrl.item_key  = s_valid && (cmd == CMD_RESTART);
            end
            ST_D_RDJ: begin
                ctrl.add_op = ADD_J_RDA;
                ctrl.ld_j   = 1'b1;
                ctrl.ld_sa  = 1'b1;
            end
            ST_D_WRI: begin
                ctrl.add_op = ADD_SA_RDB;
                ctrl.ld_sb  = 1'b1;
                ctrl.wr_en  = 1'b1;
                ctrl.wr_sel = WR_I;
            end
            ST_D_WRJ: begin
                ctrl.wr_en      = 1'b1;
                ctrl.wr_sel     = WR_J;
                ctrl.wr_from_sa = 1'b1;
                ctrl.ra_sel     = RA_T;
                ctrl.out_ld     = out_free;
            end
            ST_K_RDP: begin
                ctrl.ra_sel = RA_POS;
            end
            ST_K_ADDP: begin
                ctrl.add_op = ADD_J_RDA;
                ctrl.ld_j   = 1'b1;
                ctrl.ld_sa  = 1'b1;
            end
            ST_K_ADDK: begin
                ctrl.add_op = ADD_J_KEY;
                ctrl.ld_j   = 1'b1;
            end
            ST_K_WRP: begin
                ctrl.wr_en  = 1'b1;
                ctrl.wr_sel = WR_POS;
            end
            ST_K_WRJ: begin
                ctrl.wr_en      = 1'b1;
                ctrl.wr_sel     = WR_J;
                ctrl.wr_from_sa = 1'b1;
                ctrl.pos_step   = !last_pos;
                ctrl.key_done   = last_pos;
            end
            default: begin
                ctrl.in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/reduced_rc4_stream_cipher_top.sv -----
// Top level of the reduced RC4 stream cipher: config registers, index datapath,
// shared adder and output register. Depends on rrc4_pkg, rrc4_seq, rrc4_table.
//
//   channel   | transfer signals      | payload
//   ----------+-----------------------+--------------------------------
//   input     | s_valid / s_ready     | s_cmd, s_data_byte
//   result    | m_valid / m_ready     | m_out_byte
//   config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A data item holds the block for the accepting cycle and three steps, so s_ready
// and m_valid return together after the last step. The table RAM allows one write
// a cycle, so the swap spends ST_D_WRI and ST_D_WRJ and the keystream read waits
// on the registered read. A restart takes each table position through the ST_K_*
// states after the accepting cycle, through the single adder, and gives no result.
// Reset is synchronous and restores the identity table at once. A result waits in the
// output register; a data item stalls in its last step while it is full and unread.
module reduced_rc4_stream_cipher_top import rrc4_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [BYTE_W-1:0]    s_data_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_out_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data
);

    ctrl_t ctrl;

    logic [KEY_W-1:0]  key_bytes_reg;
    logic [KLEN_W-1:0] key_length_reg;
    idx_t              i_reg, i_next;
    idx_t              j_reg, j_next;
    idx_t              sa_reg, sb_reg, t_reg;
    idx_t              pos_reg, pos_next;
    logic [KCNT_W-1:0] kc_reg, kc_next;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] out_reg;
    logic              out_vld_reg, out_vld_next;

    idx_t              add_a, add_b, sum;
    idx_t              rd_a, rd_b;
    idx_t              raddr_a;
    idx_t              waddr, wdata;
    idx_t              ks;
    idx_t              kb;
    logic [BYTE_W-1:0] kb_byte;
    logic [KLEN_W-1:0] len_eff;
    logic              kc_last;
    logic              last_pos;
    logic              out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = ctrl.in_ready;
    assign m_valid   = out_vld_reg;
    assign m_out_byte = out_reg;
    assign out_free  = !out_vld_reg || m_ready;
    assign last_pos  = (pos_reg == idx_t'(STATE_SIZE - 1));

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_bytes_reg  <= '0;
            key_length_reg <= KLEN_W'(1);
        end else if (cfg_valid) begin
            if (cfg_index == REG_KEY_BYTES) begin
                key_bytes_reg <= cfg_data;
            end else if (cfg_index == REG_KEY_LENGTH) begin
                key_length_reg <= cfg_data[KLEN_W-1:0];
            end
        end
    end

    // Effective key length: zero length acts as one, long lengths saturate at KEY_MAX
    always_comb begin
        if (key_length_reg == '0) begin
            len_eff = KLEN_W'(1);
        end else if (key_length_reg > KLEN_W'(KEY_MAX)) begin
            len_eff = KLEN_W'(KEY_MAX);
        end else begin
            len_eff = key_length_reg;
        end
    end

    assign kc_last = ((KLEN_W'(kc_reg) + KLEN_W'(1)) >= len_eff);
    assign kb_byte = key_bytes_reg[{kc_reg, 3'b000} +: BYTE_W];
    assign kb      = kb_byte[IDX_W-1:0];

    // Shared modular adder
    always_comb begin
        case (ctrl.add_op)
            ADD_I_ONE: begin
                add_a = i_reg;
                add_b = idx_t'(1);
            end
            ADD_J_RDA: begin
                add_a = j_reg;
                add_b = rd_a;
            end
            ADD_J_KEY: begin
                add_a = j_reg;
                add_b = kb;
            end
            ADD_SA_RDB: begin
                add_a = sa_reg;
                add_b = rd_b;
            end
            default: begin
                add_a = i_reg;
                add_b = idx_t'(1);
            end
        endcase
    end

    assign sum = add_a + add_b;

    // Table addressing
    always_comb begin
        case (ctrl.ra_sel)
            RA_SUM:  raddr_a = sum;
            RA_T:    raddr_a = t_reg;
            RA_POS:  raddr_a = pos_reg;
            default: raddr_a = sum;
        endcase
        case (ctrl.wr_sel)
            WR_I:    waddr = i_reg;
            WR_J:    waddr = j_reg;
            WR_POS:  waddr = pos_reg;
            default: waddr = i_reg;
        endcase
        wdata = ctrl.wr_from_sa ? sa_reg : rd_b;
    end

    rrc4_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (ctrl.item_key),
        .we      (ctrl.wr_en),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (sum),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    rrc4_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .cmd      (s_cmd),
        .out_free (out_free),
        .last_pos (last_pos),
        .ctrl     (ctrl)
    );

    // Keystream value after the swap; forwarded when it lands on i or j
    always_comb begin
        if (t_reg == j_reg) begin
            ks = sa_reg;
        end else if (t_reg == i_reg) begin
            ks = sb_reg;
        end else begin
            ks = rd_a;
        end
    end

    // Index and counter next values
    always_comb begin
        i_next   = i_reg;
        j_next   = j_reg;
        pos_next = pos_reg;
        kc_next  = kc_reg;
        if (ctrl.item_data) begin
            i_next = sum;
        end
        if (ctrl.ld_j) begin
            j_next = sum;
        end
        if (ctrl.item_key) begin
            j_next   = '0;
            pos_next = '0;
            kc_next  = '0;
        end
        if (ctrl.pos_step) begin
            pos_next = pos_reg + idx_t'(1);
            kc_next  = kc_last ? '0 : kc_reg + KCNT_W'(1);
        end
        if (ctrl.key_done) begin
            i_next = '0;
            j_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg   <= '0;
            j_reg   <= '0;
            pos_reg <= '0;
            kc_reg  <= '0;
        end else begin
            i_reg   <= i_next;
            j_reg   <= j_next;
            pos_reg <= pos_next;
            kc_reg  <= kc_next;
        end
    end

    // Operand holding registers
    always_ff @(posedge aclk) begin
        if (ctrl.item_data) begin
            data_reg <= s_data_byte;
        end
        if (ctrl.ld_sa) begin
            sa_reg <= rd_a;
        end
        if (ctrl.ld_sb) begin
            sb_reg <= rd_b;
            t_reg  <= sum;
        end
        if (ctrl.out_ld) begin
            out_reg <= data_reg ^ BYTE_W'(ks);
        end
    end

    // Output register valid
    always_comb begin
        out_vld_next = out_vld_reg;
        if (m_ready) begin
            out_vld_next = 1'b0;
        end
        if (ctrl.out_ld) begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for reduced_rc4_stream_cipher_top: a directed table, then random
// key/data phases, checked byte by byte against an 8-entry RC4 permutation predictor.
// Depends on rrc4_pkg and the cipher RTL.
module tb_top;
    import rrc4_pkg::*;

    localparam int N_ITEMS     = 700;
    localparam int IDLE_WAIT   = 64;    // covers a full key schedule after the last transfer
    localparam int DRAIN_LIMIT = 4000;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 300;

    // Indexes past the register map; writes there must not change anything
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic                   cmd;
        logic [BYTE_W-1:0]      data;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [KEY_W-1:0]       reg_val;
        logic                   lit_ok;
        logic [BYTE_W-1:0]      lit;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_cmd;
    logic [BYTE_W-1:0]    s_data_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic [BYTE_W-1:0]    m_out_byte;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEY_W-1:0]     cfg_data;

    // Predictor state
    idx_t              perm [STATE_SIZE];
    idx_t              ci;
    idx_t              cj;
    logic [KEY_W-1:0]  key_reg;
    logic [KLEN_W-1:0] klen_reg;

    logic [BYTE_W-1:0] expected_bytes [$];
    logic [BYTE_W-1:0] want_byte;

    int n_errors   = 0;
    int n_items    = 0;
    int n_restarts = 0;
    int n_results  = 0;
    int n_reg_wr   = 0;
    bit held_off   = 0;

    // Directed rows: literal results only right after reset on the identity table
    stim_row_t dir_rows [26] = '{
        '{ROW_ITEM, CMD_DATA,    8'h00, REG_KEY_BYTES, 64'h0, 1'b1, 8'h02},
        '{ROW_ITEM, CMD_DATA,    8'hFF, REG_KEY_BYTES, 64'h0, 1'b1, 8'hFA},
        '{ROW_ITEM, CMD_DATA,    8'hA5, REG_KEY_BYTES, 64'h0, 1'b1, 8'hA2},
        '{ROW_ITEM, CMD_RESTART, 8'hFF, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_DATA,    8'h3C, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_DATA,    8'h00, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        '{ROW_REG,  CMD_DATA,    8'h00, REG_KEY_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00},
        '{ROW_REG,  CMD_DATA,    8'h00, REG_KEY_LENGTH, 64'h8, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_RESTART, 8'h00, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_DATA,    8'hFF, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_DATA,    8'h00, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        // zero length behaves as one
        '{ROW_REG,  CMD_DATA,    8'h00, REG_KEY_LENGTH, 64'h0, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_RESTART, 8'h5A, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_DATA,    8'h81, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        // length 15 saturates to eight; upper data bits are dropped
        '{ROW_REG,  CMD_DATA,    8'h00, REG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00},
        '{ROW_REG,  CMD_DATA,    8'h00, REG_KEY_BYTES, 64'h0123_4567_89AB_CDEF, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_RESTART, 8'hC3, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_DATA,    8'h7E, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_DATA,    8'h01, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        // writes past the register map are ignored
        '{ROW_REG,  CMD_DATA,    8'h00, REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00},
        '{ROW_REG,  CMD_DATA,    8'h00, REG_SPARE_HI, 64'h5555_AAAA_5555_AAAA, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_DATA,    8'hC3, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_RESTART, 8'h00, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_DATA,    8'h80, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00},
        '{ROW_REG,  CMD_DATA,    8'h00, REG_KEY_LENGTH, 64'h3, 1'b0, 8'h00},
        '{ROW_ITEM, CMD_DATA,    8'h7F, REG_KEY_BYTES, 64'h0, 1'b0, 8'h00}
    };

    reduced_rc4_stream_cipher_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    function automatic void reset_cipher_state();
        for (int p = 0; p < STATE_SIZE; p++) perm[p] = idx_t'(p);
        ci       = '0;
        cj       = '0;
        key_reg  = '0;
        klen_reg = KLEN_W'(1);
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [KEY_W-1:0] val);
        case (idx)
            REG_KEY_BYTES:  key_reg  = val;
            REG_KEY_LENGTH: klen_reg = val[KLEN_W-1:0];
            default: ;
        endcase
    endfunction

    // Key schedule: identity, then mix in key bytes cycled over the clamped length
    function automatic void run_key_schedule();
        int len;
        int jj;
        logic [7:0] kb;
        idx_t tmp;
        len = int'(klen_reg);
        if (len < 1) len = 1;
        if (len > KEY_MAX) len = KEY_MAX;
        for (int p = 0; p < STATE_SIZE; p++) perm[p] = idx_t'(p);
        jj = 0;
        for (int p = 0; p < STATE_SIZE; p++) begin
            kb       = key_reg[8*(p % len) +: 8];
            jj       = (jj + int'(perm[p]) + int'(kb)) % STATE_SIZE;
            tmp      = perm[p];
            perm[p]  = perm[jj];
            perm[jj] = tmp;
        end
        ci = '0;
        cj = '0;
    endfunction

    // One keystream step; index arithmetic wraps at the 3-bit width
    function automatic logic [BYTE_W-1:0] cipher_byte(input logic [BYTE_W-1:0] data);
        idx_t tmp;
        idx_t ks;
        ci       = ci + 1'b1;
        cj       = cj + perm[ci];
        tmp      = perm[ci];
        perm[ci] = perm[cj];
        perm[cj] = tmp;
        ks       = perm[idx_t'(perm[ci] + perm[cj])];
        return data ^ {{(BYTE_W-IDX_W){1'b0}}, ks};
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // Compare every result transfer with the oldest expected byte
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected result 0x%02h", m_out_byte));
            end else begin
                want_byte = expected_bytes.pop_front();
                if (m_out_byte !== want_byte)
                    report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                              m_out_byte, want_byte));
            end
        end
    end

    // ---------------- result side ----------------

    // Random stalls per result, burst stretches, and one long hold-off
    initial begin : result_sink
        int  gap;
        bit  rx_burst;
        m_ready  = 1'b0;
        rx_burst = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 6);
            if (!held_off && n_results >= HOLD_AT) begin
                held_off = 1;
                gap      = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // ---------------- input and register side ----------------

    // Offer one item; called and returns at a falling edge, valid left high
    task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] data, input int gap,
                             input logic lit_ok, input logic [BYTE_W-1:0] lit);
        logic [BYTE_W-1:0] pred;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_items++;
        if (cmd == CMD_RESTART) begin
            run_key_schedule();
            n_restarts++;
        end else begin
            pred = cipher_byte(data);
            expected_bytes.insert(expected_bytes.size(), lit_ok ? lit : pred);
        end
        @(negedge aclk);
    endtask

    // Drain all results, then let a pending key schedule finish
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge aclk);
        repeat (IDLE_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg_write(idx, val);
        n_reg_wr++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // ---------------- main sequence ----------------

    initial begin : stimulus
        int               plen;
        int               drain;
        bit               sx_burst;
        logic [KEY_W-1:0] val;
        logic [3:0]       klen;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_cmd       = CMD_DATA;
        s_data_byte = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_KEY_BYTES;
        cfg_data    = '0;
        reset_cipher_state();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG) begin
                wait_idle();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end else begin
                send_item(dir_rows[r].cmd, dir_rows[r].data, $urandom_range(0, 6),
                          dir_rows[r].lit_ok, dir_rows[r].lit);
            end
        end

        // Random phases: new key settings, usually a restart, then a data stream
        while (n_items < N_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0:       val = '0;
                    1:       val = '1;
                    default: val = {$urandom, $urandom};
                endcase
                write_reg(REG_KEY_BYTES, val);
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0:       klen = 4'd1;
                    1:       klen = 4'd8;
                    2:       klen = 4'd0;
                    3:       klen = 4'($urandom_range(9, 15));
                    default: klen = 4'($urandom_range(1, 8));
                endcase
                val = {$urandom, $urandom};
                val[KLEN_W-1:0] = klen;
                write_reg(REG_KEY_LENGTH, val);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI,
                          {$urandom, $urandom});

            sx_burst = ($urandom_range(0, 3) == 0);
            plen     = $urandom_range(10, 50);
            if ($urandom_range(0, 9) != 0)
                send_item(CMD_RESTART, 8'($urandom), sx_burst ? 0 : $urandom_range(0, 6),
                          1'b0, 8'h00);
            repeat (plen) begin
                send_item(($urandom_range(0, 15) == 0) ? CMD_RESTART : CMD_DATA,
                          8'($urandom), sx_burst ? 0 : $urandom_range(0, 6), 1'b0, 8'h00);
            end
        end

        // Drain
        s_valid <= 1'b0;
        drain = 0;
        while (expected_bytes.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (IDLE_WAIT) @(posedge aclk);
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived",
                                      expected_bytes.size()));

        $display("Covered %0d items (%0d key restarts) and %0d checked bytes,",
                 n_items, n_restarts, n_results);
        $display("over %0d register writes including zero, saturated and unmapped keys.",
                 n_reg_wr);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule
